>>> src/sgcf_pkg.sv
// Shared types, sizes and the successor decode for the successor-graph cycle finder.
package sgcf_pkg;

  localparam int MaxVertices = 256;
  localparam int IdxW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int CntW = $clog2(MaxVertices + 1);
  localparam int FieldW = 9;

  typedef logic signed [FieldW-1:0] successor_t;
  typedef logic [FieldW-1:0] length_t;

  // A walk pointer: either a vertex index or "none". A none pointer always
  // carries a zero index so that two none pointers compare equal.
  typedef struct packed {
    logic            none;
    logic [IdxW-1:0] idx;
  } ptr_t;

  localparam ptr_t PtrNone = '{none: 1'b1, idx: '0};
  localparam ptr_t PtrZero = '{none: 1'b0, idx: '0};

  // Turns a stored successor entry into a pointer. Negative entries and
  // entries at or beyond the loaded vertex count mean no successor.
  function automatic ptr_t decode_successor(logic [FieldW-1:0] entry,
                                            logic [CntW-1:0] count);
    ptr_t p;
    p = PtrNone;
    if (!entry[FieldW-1] && (int'(entry[FieldW-2:0]) < int'(count))) begin
      p.none = 1'b0;
      p.idx  = IdxW'(entry[FieldW-2:0]);
    end
    return p;
  endfunction

endpackage

>>> src/sgcf_if.sv
// Handshake interfaces for the vertex input channel and the result output channel.
interface sgcf_in_if;
  import sgcf_pkg::*;

  logic       valid;
  logic       ready;
  successor_t successor;
  logic       last_vertex;

  modport source (output valid, output successor, output last_vertex, input ready);
  modport sink   (input valid, input successor, input last_vertex, output ready);
endinterface

interface sgcf_out_if;
  import sgcf_pkg::*;

  logic       valid;
  logic       ready;
  logic       loop_found;
  successor_t cycle_start;
  length_t    cycle_length;
  logic       overflow;

  modport source (output valid, output loop_found, output cycle_start,
                  output cycle_length, output overflow, input ready);
  modport sink   (input valid, input loop_found, input cycle_start,
                  input cycle_length, input overflow, output ready);
endinterface

>>> src/successor_graph_cycle_finder_unit.sv
// Top level of the successor-graph cycle finder: vertex table, walk sequencer and result register.
//
// The block takes a successor graph one vertex per word on in_i, vertex 0
// first, and stores each successor in a 256-entry table. The word that
// carries last_vertex starts a tortoise-and-hare walk from vertex 0 and the
// block then drops in_i.ready until the result word has been placed in the
// output register. The walk runs on the single read port of the table:
// every pointer step has a state that presents the address and a state
// that decodes the registered entry. Each round of the meeting phase takes
// one slow step and two fast steps, each round of the phase that finds the
// first cycle vertex checks for a meeting and then steps the slow and the
// fast pointer, and counting the cycle walks the fast pointer once round it.
// The result is then handed to the output register. One result word is
// sent per graph. Vertices beyond the table capacity are dropped and
// reported through overflow. A successor that is negative or at or beyond
// the loaded vertex count means "no successor", and a graph of fewer than
// two vertices reports no loop. The output register lets the next graph
// begin loading while the previous result still waits to be taken.
module successor_graph_cycle_finder_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  sgcf_in_if.sink      in_i,
  sgcf_out_if.source   out_o
);
  import sgcf_pkg::*;

  // Sequencer codes. Each *_RD state presents a pointer to the table and the
  // matching *_WB state decodes the entry read for it.
  localparam logic [3:0] S_LOAD    = 4'd0;
  localparam logic [3:0] S_P1S_RD  = 4'd1;
  localparam logic [3:0] S_P1S_WB  = 4'd2;
  localparam logic [3:0] S_P1F1_RD = 4'd3;
  localparam logic [3:0] S_P1F1_WB = 4'd4;
  localparam logic [3:0] S_P1F2_RD = 4'd5;
  localparam logic [3:0] S_P1F2_WB = 4'd6;
  localparam logic [3:0] S_P2_CHK  = 4'd7;
  localparam logic [3:0] S_P2S_RD  = 4'd8;
  localparam logic [3:0] S_P2S_WB  = 4'd9;
  localparam logic [3:0] S_P2F_RD  = 4'd10;
  localparam logic [3:0] S_P2F_WB  = 4'd11;
  localparam logic [3:0] S_P3_RD   = 4'd12;
  localparam logic [3:0] S_P3_WB   = 4'd13;
  localparam logic [3:0] S_DONE    = 4'd14;

  logic [3:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  ptr_t            slow_q, slow_d;
  ptr_t            fast_q, fast_d;
  logic [CntW-1:0] len_q, len_d;
  logic            found_q, found_d;
  ptr_t            start_q, start_d;

  logic            out_valid_q, out_valid_d;
  logic            out_load;
  logic            res_found_q;
  successor_t      res_start_q;
  length_t         res_len_q;
  logic            res_ovf_q;

  // Successor table: one write port for loading, one registered read port
  // shared by every step of the walk.
  logic [FieldW-1:0] table_mem [MaxVertices];
  logic [FieldW-1:0] rd_data_q;
  logic              rd_none_q;
  ptr_t              rd_ptr;
  logic              wr_en;
  logic              in_fire;
  logic              table_full;
  logic [CntW-1:0]   count_inc;
  ptr_t              step_ptr;

  assign in_i.ready = (state_q == S_LOAD);
  assign in_fire    = in_i.valid && in_i.ready;
  assign table_full = (count_q == CntW'(MaxVertices));
  assign wr_en      = in_fire && !table_full;
  assign count_inc  = count_q + CntW'(1);

  // The walk reads either the slow or the fast pointer.
  always_comb begin
    unique case (state_q)
      S_P1S_RD, S_P2S_RD: rd_ptr = slow_q;
      default:            rd_ptr = fast_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[count_q[IdxW-1:0]] <= in_i.successor;
    end
    rd_data_q <= table_mem[rd_ptr.idx];
    rd_none_q <= rd_ptr.none;
  end

  // Stepping from "none" stays at "none".
  assign step_ptr = rd_none_q ? PtrNone : decode_successor(rd_data_q, count_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    slow_d      = slow_q;
    fast_d      = fast_q;
    len_d       = len_q;
    found_d     = found_q;
    start_d     = start_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;

    unique case (state_q)
      S_LOAD: begin
        if (in_fire) begin
          if (!table_full) begin
            count_d = count_inc;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.last_vertex) begin
            slow_d  = PtrZero;
            fast_d  = PtrZero;
            len_d   = '0;
            found_d = 1'b0;
            start_d = PtrNone;
            // Fewer than two stored vertices never hold a loop.
            if (!table_full && (count_inc < CntW'(2))) begin
              state_d = S_DONE;
            end else if (table_full && (count_q < CntW'(2))) begin
              state_d = S_DONE;
            end else begin
              state_d = S_P1S_RD;
            end
          end
        end
      end
      S_P1S_RD:  state_d = S_P1S_WB;
      S_P1S_WB: begin
        slow_d  = step_ptr;
        state_d = S_P1F1_RD;
      end
      S_P1F1_RD: state_d = S_P1F1_WB;
      S_P1F1_WB: begin
        fast_d  = step_ptr;
        state_d = S_P1F2_RD;
      end
      S_P1F2_RD: state_d = S_P1F2_WB;
      S_P1F2_WB: begin
        fast_d = step_ptr;
        if (step_ptr == slow_q) begin
          if (slow_q.none) begin
            // The walk ran off the graph: no loop.
            state_d = S_DONE;
          end else begin
            slow_d  = PtrZero;
            state_d = S_P2_CHK;
          end
        end else begin
          state_d = S_P1S_RD;
        end
      end
      S_P2_CHK: begin
        if (slow_q == fast_q) begin
          start_d = slow_q;
          state_d = S_P3_RD;
        end else begin
          state_d = S_P2S_RD;
        end
      end
      S_P2S_RD:  state_d = S_P2S_WB;
      S_P2S_WB: begin
        slow_d  = step_ptr;
        state_d = S_P2F_RD;
      end
      S_P2F_RD:  state_d = S_P2F_WB;
      S_P2F_WB: begin
        fast_d  = step_ptr;
        state_d = S_P2_CHK;
      end
      S_P3_RD:   state_d = S_P3_WB;
      S_P3_WB: begin
        fast_d = step_ptr;
        len_d  = len_q + CntW'(1);
        if (step_ptr == slow_q) begin
          found_d = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_P3_RD;
        end
      end
      S_DONE: begin
        // Wait for the output register to free up, then clear the loader.
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          count_d     = '0;
          ovf_d       = 1'b0;
          state_d     = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      slow_q      <= PtrZero;
      fast_q      <= PtrZero;
      len_q       <= '0;
      found_q     <= 1'b0;
      start_q     <= PtrNone;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      slow_q      <= slow_d;
      fast_q      <= fast_d;
      len_q       <= len_d;
      found_q     <= found_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result word register; only the valid bit needs a reset.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_found_q <= found_q;
      res_start_q <= found_q ? successor_t'(FieldW'(start_q.idx)) : '1;
      res_len_q   <= found_q ? FieldW'(len_q) : '0;
      res_ovf_q   <= ovf_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.loop_found   = res_found_q;
  assign out_o.cycle_start  = res_start_q;
  assign out_o.cycle_length = res_len_q;
  assign out_o.overflow     = res_ovf_q;

  // A word without a loop carries the "none" start and a zero length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.loop_found) |->
      (out_o.cycle_start == '1) && (out_o.cycle_length == '0))
    else $error("no-loop result carries a start vertex or a length");

  // A reported loop always has at least one vertex.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.loop_found) |-> (out_o.cycle_length != '0))
    else $error("loop reported with zero length");

  // Once the meeting point is found, the slow pointer stays on the graph.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_P2_CHK) || (state_q == S_P3_RD) || (state_q == S_P3_WB)) |->
      !slow_q.none)
    else $error("slow pointer left the graph after the meeting phase");

  // The loader never counts past the table capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxVertices))
    else $error("vertex count beyond table capacity");

endmodule

>>> test/successor_graph_cycle_finder_unit_tb.sv
// Self-checking testbench for the successor-graph cycle finder: graphs in, loop reports checked.
module successor_graph_cycle_finder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sgcf_pkg::*;

  // A successor value of -1 (and any walk position off the graph) means "no vertex".
  localparam int NoVertex = -1;
  // Any other negative entry must also be read as "no successor"; this one sets only the sign bit.
  localparam int SignOnlyNone = -256;
  // Settle wait before the verdict, sized for the longest walk over a full table.
  localparam int SettleCycles = 4000;
  // Generous bound over the slowest correct run of every phase below.
  localparam int CycleLimit = 1_000_000;
  localparam int ReportedMismatches = 10;

  // One loop report, in the field order of the result channel.
  typedef struct packed {
    logic       loop_found;
    successor_t cycle_start;
    length_t    cycle_length;
    logic       overflow;
  } loop_report_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sgcf_in_if  in_if ();
  sgcf_out_if out_if ();

  successor_graph_cycle_finder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #4 clk_i = ~clk_i;

  // Traffic shaping. The sender skips a cycle with probability idle_pct percent before each
  // word, and the receiver lowers ready with probability stall_pct percent in each cycle.
  int idle_pct;
  int stall_pct;

  // A long receiver hold-off is requested by a test and counted down in its own process.
  int hold_request;
  int hold_left;

  // Mirror of the block: the successor table of the graph being loaded, the number of
  // vertices stored so far and the sticky flag for vertices that did not fit.
  logic [FieldW-1:0] succ_table [MaxVertices];
  int                loaded;
  logic              overflowed;

  // Loop reports that the block still owes, oldest first.
  loop_report_t loop_reports [$];
  int           bad_reports;

  // One step along the graph. Off-graph positions, negative entries and entries that
  // point at or beyond the loaded vertex count all lead to "no vertex".
  function automatic int step_from(input int v);
    logic [FieldW-1:0] entry;
    if (v == NoVertex || v >= loaded) return NoVertex;
    entry = succ_table[v];
    if (entry[FieldW-1] || int'(entry) >= loaded) return NoVertex;
    return int'(entry);
  endfunction

  // Tortoise-and-hare walk from vertex 0 over the loaded graph. The pointers first meet
  // somewhere on the cycle (or both on "no vertex"); restarting the slow one at vertex 0
  // makes them meet again at the first cycle vertex, which is then walked round once
  // to count the cycle.
  function automatic loop_report_t walk_graph();
    loop_report_t r;
    int slow;
    int fast;
    int len;
    r.loop_found   = 1'b0;
    r.cycle_start  = successor_t'(NoVertex);
    r.cycle_length = '0;
    r.overflow     = overflowed;
    if (loaded >= 2) begin
      slow = step_from(0);
      fast = step_from(slow);
      while (slow != fast) begin
        slow = step_from(slow);
        fast = step_from(step_from(fast));
      end
      if (slow != NoVertex) begin
        slow = 0;
        while (slow != fast) begin
          slow = step_from(slow);
          fast = step_from(fast);
        end
        fast = step_from(slow);
        len  = 1;
        while (fast != slow) begin
          fast = step_from(fast);
          len++;
        end
        r.loop_found   = 1'b1;
        r.cycle_start  = successor_t'(slow);
        r.cycle_length = length_t'(len);
      end
    end
    return r;
  endfunction

  // Every accepted vertex word updates the mirror. A word marked last closes the graph,
  // even when it is itself dropped for lack of room, and owes exactly one loop report.
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      if (loaded < MaxVertices) begin
        succ_table[loaded] = in_if.successor;
        loaded++;
      end else begin
        overflowed = 1'b1;
      end
      if (in_if.last_vertex) begin
        loop_reports.push_back(walk_graph());
        loaded     = 0;
        overflowed = 1'b0;
      end
    end
  end

  task automatic report_mismatch(input string what, input loop_report_t want,
                                 input loop_report_t got);
    bad_reports++;
    if (bad_reports <= ReportedMismatches) begin
      $display("%0t ns: %s: expected loop=%0d start=%0d len=%0d ovf=%0d,", $realtime, what,
               want.loop_found, want.cycle_start, want.cycle_length, want.overflow);
      $display("    got loop=%0d start=%0d len=%0d ovf=%0d",
               got.loop_found, got.cycle_start, got.cycle_length, got.overflow);
    end
  endtask

  // Every accepted result word is checked field by field against the oldest report owed.
  always @(posedge clk_i) begin : check_result
    loop_report_t got;
    loop_report_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.loop_found   = out_if.loop_found;
      got.cycle_start  = out_if.cycle_start;
      got.cycle_length = out_if.cycle_length;
      got.overflow     = out_if.overflow;
      if (loop_reports.size() == 0) begin
        report_mismatch("result word with no report owed", '0, got);
      end else begin
        want = loop_reports.pop_front();
        if (got.loop_found !== want.loop_found || got.cycle_start !== want.cycle_start ||
            got.cycle_length !== want.cycle_length || got.overflow !== want.overflow) begin
          report_mismatch("loop report mismatch", want, got);
        end
      end
    end
  end

  // Hold-off counter. A fresh request reloads it; otherwise it counts down once per cycle.
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    <= hold_request;
      hold_request = 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: ready stays low during a hold-off and stalls at random otherwise.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one vertex word and returns after an edge once in_if.ready reads high. Valid is left high so
  // that back-to-back words need no extra assignment; an idle gap lowers it first.
  task automatic send_vertex(input successor_t succ, input logic is_last);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.successor   <= succ;
    in_if.last_vertex <= is_last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Drops valid and waits until every owed loop report has been taken.
  task automatic wait_for_reports();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (loop_reports.size() != 0);
  endtask

  // A random successor for a graph of n vertices: mostly a real vertex, sometimes "none",
  // any raw 9-bit pattern, or an index at or beyond the loaded count.
  function automatic successor_t random_successor(input int n);
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return successor_t'($urandom_range((n > MaxVertices ? MaxVertices : n) - 1));
    if (pick < 80) return successor_t'(NoVertex);
    if (pick < 90) return successor_t'($urandom_range(511));
    if (n < MaxVertices) return successor_t'($urandom_range(n, MaxVertices - 1));
    return successor_t'($urandom_range(MaxVertices - 1));
  endfunction

  // Sends one random graph and returns its size. Most graphs are small; a few fill the
  // table or spill past it. Shapes: a chain that bends back into a cycle (a rho), a chain
  // that runs out, and fully random successors. Well-formed shapes get a little noise.
  task automatic send_random_graph(output int n);
    int pick;
    int shape;
    int bend;
    successor_t succ;
    pick = $urandom_range(999);
    if (pick < 20) n = $urandom_range(200, MaxVertices + 4);
    else if (pick < 150) n = $urandom_range(13, 64);
    else if (pick < 190) n = 1;
    else n = $urandom_range(2, 12);
    shape = $urandom_range(9);
    bend  = $urandom_range((n > MaxVertices ? MaxVertices : n) - 1);
    for (int i = 0; i < n; i++) begin
      if (shape < 5) begin
        succ = successor_t'(i + 1);
        if (i == n - 1) succ = (shape < 4) ? successor_t'(bend) : random_successor(n);
        if ($urandom_range(19) == 0) succ = random_successor(n);
      end else begin
        succ = random_successor(n);
      end
      send_vertex(succ, i == n - 1);
    end
  endtask

  // Small hand-built graphs: short graphs, self loops, a loop of two vertices, every flavor of
  // "no successor", a rho with a tail and a loop that vertex 0 cannot reach.
  task automatic test_directed_graphs();
    idle_pct  = 0;
    stall_pct = 0;
    // A single vertex never reports a loop, even when it points at itself.
    send_vertex(0, 1'b1);
    // Loop of two vertices through vertex 0.
    send_vertex(1, 1'b0);
    send_vertex(0, 1'b1);
    // Self loop at vertex 0.
    send_vertex(0, 1'b0);
    send_vertex(successor_t'(NoVertex), 1'b1);
    // Self loop at the second vertex.
    send_vertex(1, 1'b0);
    send_vertex(1, 1'b1);
    // Chain that ends in "none".
    send_vertex(1, 1'b0);
    send_vertex(successor_t'(NoVertex), 1'b1);
    // A negative entry other than -1.
    send_vertex(1, 1'b0);
    send_vertex(successor_t'(SignOnlyNone), 1'b1);
    // An index equal to the loaded count, then the largest index in a tiny graph.
    send_vertex(1, 1'b0);
    send_vertex(2, 1'b1);
    send_vertex(successor_t'(MaxVertices - 1), 1'b0);
    send_vertex(0, 1'b1);
    // Rho: tail 0 -> 1, cycle 2 -> 3 -> 4 -> 2.
    send_vertex(1, 1'b0);
    send_vertex(2, 1'b0);
    send_vertex(3, 1'b0);
    send_vertex(4, 1'b0);
    send_vertex(2, 1'b1);
    // Vertex 0 leads nowhere; the loop between vertices 1 and 2 is unreachable.
    send_vertex(successor_t'(NoVertex), 1'b0);
    send_vertex(2, 1'b0);
    send_vertex(1, 1'b1);
    wait_for_reports();
  endtask

  // Graphs that fill the table: a cycle through all 256 vertices, a full-length tail into
  // a self loop at the top index, and a graph that spills over with its last word dropped.
  task automatic test_full_table();
    idle_pct  = 21;
    stall_pct = 21;
    for (int i = 0; i < MaxVertices; i++) begin
      send_vertex(successor_t'(i == MaxVertices - 1 ? 0 : i + 1), i == MaxVertices - 1);
    end
    for (int i = 0; i < MaxVertices; i++) begin
      send_vertex(successor_t'(i == MaxVertices - 1 ? i : i + 1), i == MaxVertices - 1);
    end
    // Three words beyond capacity; the one marked last is dropped but still starts the walk.
    for (int i = 0; i < MaxVertices + 3; i++) begin
      send_vertex(successor_t'(i == MaxVertices - 1 ? MaxVertices / 2 : i + 1),
                  i == MaxVertices + 2);
    end
    // The overflow flag must not leak into the next graph.
    send_vertex(1, 1'b0);
    send_vertex(0, 1'b1);
    wait_for_reports();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering small graphs,
  // so the output register fills, the next walk finishes and the input has to stall.
  task automatic test_output_backpressure();
    int n;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_request = 3000;
    @(posedge clk_i);
    for (int g = 0; g < 8; g++) begin
      n = $urandom_range(2, 8);
      for (int i = 0; i < n; i++) send_vertex(random_successor(n), i == n - 1);
    end
    wait_for_reports();
  endtask

  // Random graphs under one traffic profile until the vertex budget is used up.
  task automatic test_random_graphs(input int vertex_budget, input int idle, input int stall);
    int sent;
    int n;
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    while (sent < vertex_budget) begin
      send_random_graph(n);
      sent += n;
    end
    wait_for_reports();
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.successor   = '0;
    in_if.last_vertex = 1'b0;
    out_if.ready      = 1'b0;
    idle_pct          = 0;
    stall_pct         = 0;
    hold_request      = 0;
    hold_left         = 0;
    loaded            = 0;
    overflowed        = 1'b0;
    bad_reports       = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_graphs();
    test_full_table();
    test_output_backpressure();
    test_random_graphs(110, 0, 0);
    test_random_graphs(100, 83, 0);
    test_random_graphs(100, 0, 83);
    test_random_graphs(100, 21, 21);

    // Give a stray result word time to show up before the verdict.
    repeat (SettleCycles) @(posedge clk_i);
    if (loop_reports.size() != 0) bad_reports++;
    if (bad_reports == 0) begin
      $display("successor_graph_cycle_finder_unit verification clean");
    end else begin
      $display("successor_graph_cycle_finder_unit verification failed");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("successor_graph_cycle_finder_unit verification failed");
    $finish;
  end

endmodule

>>> filelist.f
src/sgcf_pkg.sv
src/sgcf_if.sv
src/successor_graph_cycle_finder_unit.sv
test/successor_graph_cycle_finder_unit_tb.sv
